### hw/rtl/dpi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpi_pkg: shared types and constants of the damped particle integrator
// Word layouts, command codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package dpi_pkg;

   // fixed point widths
   localparam int QW       = 32;
   localparam int TsW      = 16;
   localparam int DampW    = 17;
   localparam int FracW    = 16;
   localparam int MulW     = QW + 1;
   localparam int ProdW    = 2 * MulW;
   localparam int SumW     = ProdW - FracW + 1;
   localparam int CsrIdxW  = 3;
   localparam int AxisN    = 3;
   localparam int AxisW    = $clog2(AxisN);

   // command codes of an input word
   typedef enum logic [1:0] {
      CMD_FORCE    = 2'd0,
      CMD_STEP     = 2'd1,
      CMD_LOAD_POS = 2'd2,
      CMD_LOAD_VEL = 2'd3
   } cmd_type;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_TIME_STEP = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_DAMPING   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_INV_MASS  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ACCEL_X   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_ACCEL_Y   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_ACCEL_Z   = 3'd5;

   // register reset values
   localparam logic [TsW-1:0]          RST_TIME_STEP = 16'd1092;
   localparam logic [DampW-1:0]        RST_DAMPING   = 17'd65535;
   localparam logic [QW-1:0]           RST_INV_MASS  = 32'd0;
   localparam logic signed [QW-1:0]    RST_ACCEL_X   = 32'sd0;
   localparam logic signed [QW-1:0]    RST_ACCEL_Y   = -32'sd655360;
   localparam logic signed [QW-1:0]    RST_ACCEL_Z   = 32'sd0;

   // one in q16.16, used to pass a value through the multiplier unchanged
   localparam logic signed [MulW-1:0]  ONE_Q16 = 33'sd65536;

   typedef struct packed {
      cmd_type                 cmd;
      logic signed [QW-1:0]    vec_x;
      logic signed [QW-1:0]    vec_y;
      logic signed [QW-1:0]    vec_z;
   } req_type;

   typedef struct packed {
      logic signed [QW-1:0]    pos_x;
      logic signed [QW-1:0]    pos_y;
      logic signed [QW-1:0]    pos_z;
      logic signed [QW-1:0]    vel_x;
      logic signed [QW-1:0]    vel_y;
      logic signed [QW-1:0]    vel_z;
      logic                    frozen;
      logic                    saturated;
   } rsp_type;

   typedef struct packed {
      logic [TsW-1:0]          time_step;
      logic [DampW-1:0]        damping_per_step;
      logic [QW-1:0]           inverse_mass;
      logic signed [QW-1:0]    base_accel_x;
      logic signed [QW-1:0]    base_accel_y;
      logic signed [QW-1:0]    base_accel_z;
   } cfg_type;

endpackage

### hw/rtl/dpi_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpi_csr: configuration registers
// Holds step, damping, inverse mass and base acceleration; always ready.
// ---------------------------------------------------------------------------
module dpi_csr import dpi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [QW-1:0]       csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TIME_STEP: cfg_in.time_step        = csr_wdata[TsW-1:0];
            CSR_DAMPING:   cfg_in.damping_per_step = csr_wdata[DampW-1:0];
            CSR_INV_MASS:  cfg_in.inverse_mass     = csr_wdata;
            CSR_ACCEL_X:   cfg_in.base_accel_x     = signed'(csr_wdata);
            CSR_ACCEL_Y:   cfg_in.base_accel_y     = signed'(csr_wdata);
            CSR_ACCEL_Z:   cfg_in.base_accel_z     = signed'(csr_wdata);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step        <= RST_TIME_STEP;
         cfg_ff.damping_per_step <= RST_DAMPING;
         cfg_ff.inverse_mass     <= RST_INV_MASS;
         cfg_ff.base_accel_x     <= RST_ACCEL_X;
         cfg_ff.base_accel_y     <= RST_ACCEL_Y;
         cfg_ff.base_accel_z     <= RST_ACCEL_Z;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### hw/rtl/dpi_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dpi_mac: shared multiply, shift and saturating add unit
// The product a*b is registered; clamp(floor(p / 2^16) + addend) is formed from that register.
// ---------------------------------------------------------------------------
module dpi_mac import dpi_pkg::*; (
   input  logic                   clock,
   input  logic                   mul_en,
   input  logic signed [MulW-1:0] mul_a,
   input  logic signed [MulW-1:0] mul_b,
   input  logic signed [QW-1:0]   addend,
   output logic signed [QW-1:0]   result,
   output logic                   clamped
);

   logic signed [ProdW-1:0] product_ff, product_in;
   logic signed [SumW-1:0]  sum;
   logic                    over_hi, over_lo;

   assign product_in = mul_a * mul_b;

   // product register, payload only
   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   // arithmetic shift is floor, then add with sign extension
   assign sum = signed'({product_ff[ProdW-1], product_ff[ProdW-1:FracW]})
              + signed'({{(SumW-QW){addend[QW-1]}}, addend});

   // out of range when the bits above the q16.16 sign disagree with it
   assign over_hi = !sum[SumW-1] && (|sum[SumW-2:QW-1]);
   assign over_lo = sum[SumW-1] && !(&sum[SumW-2:QW-1]);
   assign clamped = over_hi || over_lo;

   always_comb begin
      if (over_hi) begin
         result = {1'b0, {(QW-1){1'b1}}};
      end else if (over_lo) begin
         result = {1'b1, {(QW-1){1'b0}}};
      end else begin
         result = sum[QW-1:0];
      end
   end

endmodule

### hw/rtl/damped_particle_integrator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// damped_particle_integrator: fixed point damped euler step for one particle
// Position, velocity and force sum per axis, all products on one multiplier.
// ---------------------------------------------------------------------------
// a load or a frozen step goes from idle straight to done; add force and
// time step first run their products on the shared multiplier. the next
// word is taken once the block is back in idle. each product passes a
// multiply state, then a shift and clamp state: three per force, twelve per step.
// synchronous reset clears position, velocity and force sum and loads the
// register defaults; no result is pending after reset.
module damped_particle_integrator import dpi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [QW-1:0]       csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC, ST_DONE} state_type;
   typedef enum logic [2:0] {OP_POS, OP_ACCEL, OP_VEL, OP_DAMP, OP_FORCE} op_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [AxisW-1:0] axis_ff, axis_in;
   logic signed [QW-1:0] pos_ff [AxisN];
   logic signed [QW-1:0] pos_in [AxisN];
   logic signed [QW-1:0] vel_ff [AxisN];
   logic signed [QW-1:0] vel_in [AxisN];
   logic signed [QW-1:0] fs_ff  [AxisN];
   logic signed [QW-1:0] fs_in  [AxisN];
   logic signed [QW-1:0] vec_ff [AxisN];
   logic signed [QW-1:0] vec_in [AxisN];
   logic signed [QW-1:0] acc_ff, acc_in;
   logic    sat_ff, sat_in;
   logic    frozen_ff, frozen_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                   mul_en;
   logic signed [MulW-1:0] mul_a, mul_b;
   logic signed [QW-1:0]   addend, mac_result, base_accel;
   logic                   mac_clamped;

   dpi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dpi_mac u_mac (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .addend  (addend),
      .result  (mac_result),
      .clamped (mac_clamped)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // base acceleration of the current axis
   always_comb begin
      case (axis_ff)
         2'd0:    base_accel = cfg.base_accel_x;
         2'd1:    base_accel = cfg.base_accel_y;
         default: base_accel = cfg.base_accel_z;
      endcase
   end

   // operand select for the shared unit
   always_comb begin
      mul_en = (state_ff == ST_MUL);
      case (op_ff)
         OP_POS: begin
            mul_a  = MulW'(vel_ff[axis_ff]);
            mul_b  = signed'({{(MulW-TsW){1'b0}}, cfg.time_step});
            addend = pos_ff[axis_ff];
         end
         OP_ACCEL: begin
            mul_a  = MulW'(fs_ff[axis_ff]);
            mul_b  = signed'({1'b0, cfg.inverse_mass});
            addend = base_accel;
         end
         OP_VEL: begin
            mul_a  = MulW'(acc_ff);
            mul_b  = signed'({{(MulW-TsW){1'b0}}, cfg.time_step});
            addend = vel_ff[axis_ff];
         end
         OP_DAMP: begin
            mul_a  = MulW'(vel_ff[axis_ff]);
            mul_b  = signed'({{(MulW-DampW){1'b0}}, cfg.damping_per_step});
            addend = '0;
         end
         default: begin
            mul_a  = MulW'(vec_ff[axis_ff]);
            mul_b  = ONE_Q16;
            addend = fs_ff[axis_ff];
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      axis_in      = axis_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      fs_in        = fs_ff;
      vec_in       = vec_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      frozen_in    = frozen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vec_in[0] = req_data.vec_x;
               vec_in[1] = req_data.vec_y;
               vec_in[2] = req_data.vec_z;
               sat_in    = 1'b0;
               frozen_in = 1'b0;
               axis_in   = '0;
               unique case (req_data.cmd)
                  CMD_FORCE: begin
                     op_in    = OP_FORCE;
                     state_in = ST_MUL;
                  end
                  CMD_STEP: begin
                     op_in = OP_POS;
                     if (cfg.inverse_mass == '0) begin
                        frozen_in = 1'b1;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  CMD_LOAD_POS: begin
                     op_in     = OP_FORCE;
                     pos_in[0] = req_data.vec_x;
                     pos_in[1] = req_data.vec_y;
                     pos_in[2] = req_data.vec_z;
                     state_in  = ST_DONE;
                  end
                  CMD_LOAD_VEL: begin
                     op_in     = OP_FORCE;
                     vel_in[0] = req_data.vec_x;
                     vel_in[1] = req_data.vec_y;
                     vel_in[2] = req_data.vec_z;
                     state_in  = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sat_in = sat_ff || mac_clamped;
            case (op_ff)
               OP_POS:   pos_in[axis_ff] = mac_result;
               OP_ACCEL: acc_in          = mac_result;
               OP_VEL:   vel_in[axis_ff] = mac_result;
               OP_DAMP: begin
                  vel_in[axis_ff] = mac_result;
                  fs_in[axis_ff]  = '0;
               end
               default:  fs_in[axis_ff]  = mac_result;
            endcase
            // advance to the next product, or to done after the last one
            state_in = ST_MUL;
            case (op_ff)
               OP_POS:   op_in = OP_ACCEL;
               OP_ACCEL: op_in = OP_VEL;
               OP_VEL:   op_in = OP_DAMP;
               default: begin
                  if (axis_ff == AxisW'(AxisN - 1)) begin
                     state_in = ST_DONE;
                  end else begin
                     axis_in = axis_ff + 1'b1;
                     if (op_ff == OP_DAMP) begin
                        op_in = OP_POS;
                     end
                  end
               end
            endcase
         end
         ST_DONE: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.pos_x     = pos_ff[0];
               rsp_data_in.pos_y     = pos_ff[1];
               rsp_data_in.pos_z     = pos_ff[2];
               rsp_data_in.vel_x     = vel_ff[0];
               rsp_data_in.vel_y     = vel_ff[1];
               rsp_data_in.vel_z     = vel_ff[2];
               rsp_data_in.frozen    = frozen_ff;
               rsp_data_in.saturated = sat_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FORCE;
         axis_ff      <= '0;
         sat_ff       <= 1'b0;
         frozen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AxisN; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            fs_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         axis_ff      <= axis_in;
         sat_ff       <= sat_in;
         frozen_ff    <= frozen_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         fs_ff        <= fs_in;
      end
      vec_ff      <= vec_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a skipped step never clamps anything
   a_frozen_not_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frozen && rsp_data.saturated))
      else $error("frozen result flagged as saturated");

   // one word at a time: no accept right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word accepted while busy");

   // the axis counter stays within the three axes
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != AxisW'(AxisN))
      else $error("axis counter out of range");

   // a completed step leaves the force sum cleared
   a_force_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == OP_DAMP && !frozen_ff)
      |-> (fs_ff[0] == '0 && fs_ff[1] == '0 && fs_ff[2] == '0))
      else $error("force sum not cleared after a step");

endmodule

### test/tb_damped_particle_integrator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_damped_particle_integrator: self-checking bench of the particle integrator
// A directed table of words and register writes runs first, then random
// phases with fresh register settings. Each accepted word is run through an
// in-bench fixed point integrator, and every returned state word is checked
// field by field against the oldest expected state. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb_damped_particle_integrator;
   import dpi_pkg::*;

   localparam logic signed [QW-1:0] Q_TOP    = 32'sh7fffffff;
   localparam logic signed [QW-1:0] Q_BOTTOM = 32'sh80000000;
   // indexes that decode to no register
   localparam logic [CsrIdxW-1:0]   CSR_SPARE_LO = 3'd6;
   localparam logic [CsrIdxW-1:0]   CSR_SPARE_HI = 3'd7;
   localparam int                   LONG_HOLD    = 400;
   localparam int                   TAIL_CYCLES  = 40;
   localparam int                   PHASES       = 13;
   localparam int                   PHASE_WORDS  = 100;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index;
   logic [QW-1:0]       csr_wdata;

   // one row of the directed table: a register write or a word
   typedef struct packed {
      logic               is_csr;
      logic [CsrIdxW-1:0] index;
      logic [QW-1:0]      wdata;
      req_type            word;
      logic               typed;
      rsp_type            want;
   } plan_row_type;

   plan_row_type        plan [$];
   rsp_type             expected_states [$];
   int                  fault_count;
   bit                  stall_mode;
   bit                  long_hold_req;

   // tracked particle state and register copy
   logic signed [QW-1:0] particle_pos   [AxisN];
   logic signed [QW-1:0] particle_vel   [AxisN];
   logic signed [QW-1:0] particle_force [AxisN];
   cfg_type              particle_cfg;

   damped_particle_integrator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_damped_particle_integrator failed");
      $finish;
   end

   // saturate to q16.16 and flag the clamp
   function automatic logic signed [QW-1:0] clamp_q(longint v, inout bit sat);
      if (v > longint'(Q_TOP)) begin
         sat = 1'b1;
         return Q_TOP;
      end
      if (v < longint'(Q_BOTTOM)) begin
         sat = 1'b1;
         return Q_BOTTOM;
      end
      return v[QW-1:0];
   endfunction

   // one word through the integrator, returns the state after it
   function automatic rsp_type advance_particle(req_type w);
      rsp_type              r;
      bit                   sat = 1'b0;
      bit                   frz = 1'b0;
      int                   a;
      logic signed [QW-1:0] vec   [AxisN];
      logic signed [QW-1:0] accel [AxisN];
      logic signed [QW-1:0] a32;
      logic signed [QW-1:0] v1;
      longint               v;
      longint               acc;
      vec[0] = w.vec_x;
      vec[1] = w.vec_y;
      vec[2] = w.vec_z;
      accel[0] = particle_cfg.base_accel_x;
      accel[1] = particle_cfg.base_accel_y;
      accel[2] = particle_cfg.base_accel_z;
      case (w.cmd)
         CMD_FORCE: begin
            for (a = 0; a < AxisN; a++)
               particle_force[a] = clamp_q(longint'(particle_force[a]) + longint'(vec[a]),
                                           sat);
         end
         CMD_LOAD_POS: begin
            for (a = 0; a < AxisN; a++) particle_pos[a] = vec[a];
         end
         CMD_LOAD_VEL: begin
            for (a = 0; a < AxisN; a++) particle_vel[a] = vec[a];
         end
         default: begin
            // infinite mass: nothing moves, force sum is kept
            if (particle_cfg.inverse_mass == '0) begin
               frz = 1'b1;
            end else begin
               for (a = 0; a < AxisN; a++) begin
                  v = longint'(particle_vel[a]);
                  particle_pos[a] = clamp_q(longint'(particle_pos[a]) +
                     ((v * longint'(particle_cfg.time_step)) >>> FracW), sat);
                  acc = ((longint'(particle_force[a]) *
                          longint'(particle_cfg.inverse_mass)) >>> FracW) +
                        longint'(accel[a]);
                  a32 = clamp_q(acc, sat);
                  v1 = clamp_q(v + ((longint'(a32) *
                       longint'(particle_cfg.time_step)) >>> FracW), sat);
                  particle_vel[a] = clamp_q((longint'(v1) *
                       longint'(particle_cfg.damping_per_step)) >>> FracW, sat);
                  particle_force[a] = '0;
               end
            end
         end
      endcase
      r.pos_x     = particle_pos[0];
      r.pos_y     = particle_pos[1];
      r.pos_z     = particle_pos[2];
      r.vel_x     = particle_vel[0];
      r.vel_y     = particle_vel[1];
      r.vel_z     = particle_vel[2];
      r.frozen    = frz;
      r.saturated = sat;
      return r;
   endfunction

   // register write into the tracked copy, upper bits dropped
   function automatic void apply_csr(logic [CsrIdxW-1:0] idx, logic [QW-1:0] data);
      case (idx)
         CSR_TIME_STEP: particle_cfg.time_step        = data[TsW-1:0];
         CSR_DAMPING:   particle_cfg.damping_per_step = data[DampW-1:0];
         CSR_INV_MASS:  particle_cfg.inverse_mass     = data;
         CSR_ACCEL_X:   particle_cfg.base_accel_x     = data;
         CSR_ACCEL_Y:   particle_cfg.base_accel_y     = data;
         CSR_ACCEL_Z:   particle_cfg.base_accel_z     = data;
         default: ;
      endcase
   endfunction

   function automatic rsp_type pack_state(logic [QW-1:0] px, logic [QW-1:0] py,
                                          logic [QW-1:0] pz, logic [QW-1:0] vx,
                                          logic [QW-1:0] vy, logic [QW-1:0] vz,
                                          logic frz, logic sat);
      return rsp_type'({px, py, pz, vx, vy, vz, frz, sat});
   endfunction

   function automatic plan_row_type word_row(cmd_type c, logic [QW-1:0] x,
                                             logic [QW-1:0] y, logic [QW-1:0] z);
      plan_row_type r;
      r = '0;
      r.word = req_type'({c, x, y, z});
      return r;
   endfunction

   function automatic plan_row_type typed_row(cmd_type c, logic [QW-1:0] x,
                                              logic [QW-1:0] y, logic [QW-1:0] z,
                                              rsp_type want);
      plan_row_type r;
      r = word_row(c, x, y, z);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CsrIdxW-1:0] idx, logic [QW-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.index = idx;
      r.wdata = data;
      return r;
   endfunction

   // extremes, small physical values and full-range noise
   function automatic logic [QW-1:0] rand_q();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'd0;
         3, 4, 5, 6: return 32'($urandom_range(0, 32'h00200000)) - 32'h00100000;
         default: return $urandom;
      endcase
   endfunction

   // drop both channels and wait for every word to come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_states.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [QW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
   endtask

   // offer one word, optionally after a random gap, and log its expected state
   task automatic send_word(req_type w, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = (stall_mode && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      @(negedge clock);
      csr_valid <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      predicted = advance_particle(w);
      expected_states.push_back(typed ? want : predicted);
   endtask

   // receiver: random ready bursts, plus one long hold on request
   initial begin : rsp_side
      int burst;
      rsp_ready = 1'b0;
      burst = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            burst = 0;
         end else if (burst > 0) begin
            burst--;
         end else if (stall_mode && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(0, 9);
         end else begin
            rsp_ready <= 1'b1;
            burst = stall_mode ? $urandom_range(0, 15) : 0;
         end
      end
   end

   // result check against the oldest expected state
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_states.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected word at %0t: pos %h %h %h vel %h %h %h frz %b sat %b",
                        $realtime, rsp_data.pos_x, rsp_data.pos_y, rsp_data.pos_z,
                        rsp_data.vel_x, rsp_data.vel_y, rsp_data.vel_z,
                        rsp_data.frozen, rsp_data.saturated);
         end else begin
            want = expected_states.pop_front();
            if (rsp_data.pos_x !== want.pos_x || rsp_data.pos_y !== want.pos_y ||
                rsp_data.pos_z !== want.pos_z || rsp_data.vel_x !== want.vel_x ||
                rsp_data.vel_y !== want.vel_y || rsp_data.vel_z !== want.vel_z ||
                rsp_data.frozen !== want.frozen ||
                rsp_data.saturated !== want.saturated) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  want pos %h %h %h vel %h %h %h frz %b sat %b",
                           want.pos_x, want.pos_y, want.pos_z, want.vel_x, want.vel_y,
                           want.vel_z, want.frozen, want.saturated);
                  $display("  got  pos %h %h %h vel %h %h %h frz %b sat %b",
                           rsp_data.pos_x, rsp_data.pos_y, rsp_data.pos_z,
                           rsp_data.vel_x, rsp_data.vel_y, rsp_data.vel_z,
                           rsp_data.frozen, rsp_data.saturated);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int             k;
      int             p;
      int             n;
      req_type        w;
      logic [TsW-1:0]   ts;
      logic [DampW-1:0] damp;
      logic [QW-1:0]    inv_mass;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_mode = 1'b1;
      long_hold_req = 1'b0;
      fault_count = 0;
      for (k = 0; k < AxisN; k++) begin
         particle_pos[k] = '0;
         particle_vel[k] = '0;
         particle_force[k] = '0;
      end
      particle_cfg = '{RST_TIME_STEP, RST_DAMPING, RST_INV_MASS,
                       RST_ACCEL_X, RST_ACCEL_Y, RST_ACCEL_Z};

      // reset defaults: infinite mass, loads, force clamp
      plan.push_back(typed_row(CMD_STEP, 32'd1, 32'd2, 32'd3,
                               pack_state(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)));
      plan.push_back(typed_row(CMD_LOAD_POS, 32'h7fffffff, 32'h80000000, 32'd0,
                               pack_state(32'h7fffffff, 32'h80000000, 0, 0, 0, 0,
                                          1'b0, 1'b0)));
      plan.push_back(typed_row(CMD_LOAD_VEL, 32'h80000000, 32'h7fffffff, 32'hffffffff,
                               pack_state(32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                                          32'h7fffffff, 32'hffffffff, 1'b0, 1'b0)));
      plan.push_back(typed_row(CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'd0,
                               pack_state(32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                                          32'h7fffffff, 32'hffffffff, 1'b0, 1'b0)));
      plan.push_back(typed_row(CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'd0,
                               pack_state(32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                                          32'h7fffffff, 32'hffffffff, 1'b0, 1'b1)));
      plan.push_back(typed_row(CMD_STEP, 32'd0, 32'd0, 32'd0,
                               pack_state(32'h7fffffff, 32'h80000000, 0, 32'h80000000,
                                          32'h7fffffff, 32'hffffffff, 1'b1, 1'b0)));
      // largest inverse mass and extreme base acceleration: acceleration clamp
      plan.push_back(csr_row(CSR_INV_MASS, 32'hffffffff));
      plan.push_back(csr_row(CSR_ACCEL_X, 32'h7fffffff));
      plan.push_back(csr_row(CSR_ACCEL_Z, 32'h80000000));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_FORCE, 32'd1, 32'hffffffff, 32'h00010000));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      // zero time step with the largest damping gain
      plan.push_back(csr_row(CSR_TIME_STEP, 32'd0));
      plan.push_back(csr_row(CSR_DAMPING, 32'h0001ffff));
      plan.push_back(csr_row(CSR_INV_MASS, 32'h00010000));
      plan.push_back(csr_row(CSR_ACCEL_Y, 32'd0));
      plan.push_back(word_row(CMD_LOAD_VEL, 32'h00010000, 32'hffff0000, 32'h40000000));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_FORCE, 32'h00050000, 32'hfffb0000, 32'd7));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      // longest step, no damping, spare indexes
      plan.push_back(csr_row(CSR_TIME_STEP, 32'hffffffff));
      plan.push_back(csr_row(CSR_DAMPING, 32'd0));
      plan.push_back(csr_row(CSR_ACCEL_X, 32'd0));
      plan.push_back(csr_row(CSR_SPARE_LO, 32'hffffffff));
      plan.push_back(csr_row(CSR_SPARE_HI, 32'hffffffff));
      plan.push_back(word_row(CMD_LOAD_POS, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_LOAD_VEL, 32'h7fffffff, 32'h80000000, 32'h12345678));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      // damping of exactly one, negative force clamp, position clamp
      plan.push_back(csr_row(CSR_TIME_STEP, 32'd1092));
      plan.push_back(csr_row(CSR_DAMPING, 32'h00010000));
      plan.push_back(csr_row(CSR_INV_MASS, 32'h00008000));
      plan.push_back(csr_row(CSR_ACCEL_Y, 32'hfff60000));
      plan.push_back(word_row(CMD_FORCE, 32'h80000000, 32'h80000000, 32'h80000000));
      plan.push_back(word_row(CMD_FORCE, 32'h80000000, 32'h80000000, 32'h80000000));
      plan.push_back(word_row(CMD_LOAD_VEL, 32'h00a00000, 32'hff600000, 32'h00000001));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));
      plan.push_back(word_row(CMD_LOAD_POS, 32'h7fffffff, 32'h80000000, 32'h7ffffff0));
      plan.push_back(word_row(CMD_STEP, 32'd0, 32'd0, 32'd0));

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            wait_idle();
            write_csr(plan[k].index, plan[k].wdata);
         end else begin
            send_word(plan[k].word, plan[k].typed, plan[k].want);
         end
      end

      // random phases, each under a new register setting
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p % 5)
            0: ts = 16'hffff;
            1: ts = 16'($urandom_range(1, 4096));
            2: ts = 16'd1;
            default: ts = 16'($urandom_range(0, 65535));
         endcase
         case (p % 5)
            0: damp = 17'h10000;
            1: damp = 17'($urandom_range(60000, 65536));
            2: damp = 17'($urandom_range(0, 131071));
            3: damp = 17'h1ffff;
            default: damp = 17'($urandom_range(64000, 65535));
         endcase
         case (p % 6)
            0: inv_mass = '0;
            1: inv_mass = 32'hffffffff;
            2, 3: inv_mass = 32'($urandom_range(256, 262144));
            4: inv_mass = $urandom;
            default: inv_mass = 32'h00010000;
         endcase
         write_csr(CSR_TIME_STEP, {16'($urandom), ts});
         write_csr(CSR_DAMPING, {15'($urandom), damp});
         write_csr(CSR_INV_MASS, inv_mass);
         write_csr(CSR_ACCEL_X, rand_q());
         write_csr(CSR_ACCEL_Y, rand_q());
         write_csr(CSR_ACCEL_Z, rand_q());
         // a quiet stretch midway, none at all near the end
         stall_mode = (p < PHASES - 2) && (p != 3);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (p == 5 && n == 20) long_hold_req = 1'b1;
            case ($urandom_range(0, 9))
               0, 1, 2: w.cmd = CMD_FORCE;
               3, 4, 5: w.cmd = CMD_STEP;
               6, 7:    w.cmd = CMD_LOAD_VEL;
               default: w.cmd = CMD_LOAD_POS;
            endcase
            w.vec_x = rand_q();
            w.vec_y = rand_q();
            w.vec_z = rand_q();
            send_word(w, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fault_count == 0 && expected_states.size() == 0) begin
         $display("tb_damped_particle_integrator passed");
      end else begin
         $display("tb_damped_particle_integrator failed");
      end
      $finish;
   end

endmodule
